// File: hdl/hjss_pkg.sv
// ============================================================================
// hjss_pkg
// Shared types and constants for the Jacobi heat stencil sweep unit.
// ============================================================================

package hjss_pkg;

    // Grid geometry
    localparam int GRID_ROWS = 256;
    localparam int GRID_COLS = 256;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);

    // Field widths
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int FRAC_W  = 16;
    localparam int LAP_W   = VAL_W + 4;             // n+s+w+e-4c, exact
    localparam int PROD_W  = LAP_W + COEF_W + 1;    // k (unsigned) * lap
    localparam int DELTA_W = PROD_W - FRAC_W;
    localparam int SUM_W   = DELTA_W + 1;
    localparam int RCMP_W  = (ROW_W > IDX_W) ? ROW_W : IDX_W;
    localparam int CCMP_W  = (COL_W > IDX_W) ? COL_W : IDX_W;

    // Output queue, counted in input words (each holds up to two results)
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // APB register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_COEF    = 2'd0;
    localparam logic [1:0] REG_SRC_VAL = 2'd1;
    localparam logic [1:0] REG_SRC_ROW = 2'd2;
    localparam logic [1:0] REG_SRC_COL = 2'd3;

    // Register reset values
    localparam logic [COEF_W-1:0]       COEF_RST    = 16'd6554;
    localparam logic signed [VAL_W-1:0] SRC_VAL_RST = 32'sd6553600;
    localparam logic [IDX_W-1:0]        SRC_ROW_RST = 8'd128;
    localparam logic [IDX_W-1:0]        SRC_COL_RST = 8'd128;

    // Saturation bounds
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // One queued input word: the row-behind result and, on the last row,
    // the word's own border cell.
    typedef struct packed {
        logic [VAL_W-1:0] val0;
        logic [VAL_W-1:0] val1;
        logic [IDX_W-1:0] row0;
        logic [IDX_W-1:0] row1;
        logic [IDX_W-1:0] col;
        logic             dual;
        logic             flast1;
    } t_pair;

endpackage

// File: hdl/heat_jacobi_stencil_sweep_unit.sv
// ============================================================================
// heat_jacobi_stencil_sweep_unit
// One Jacobi sweep of the 5-point heat stencil over a raster-ordered grid,
// with two row memories, a three-stage arithmetic pipe and an output queue.
// ============================================================================
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_cell_value, i_frame_start
//  out     | output    | o_out_valid / i_out_ready  | o_new_value, o_out_row,
//          |           |                            | o_out_col, o_run_last,
//          |           |                            | o_frame_last
//  config  | APB       | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  One input word per cycle while o_in_ready is high; on the last grid row each
//  word gives two results, which the single output port sends one after the other.
//  An accepted word passes through stages 1, 2 and 3 into the output queue;
//  its results are then shown from the queue head.
//  The row memories are read at acceptance, so each accepted word is processed
//  in order with no gaps.
//  o_in_ready drops when the queued words and the words in the pipe fill the
//  8-word output queue; stalls at the output never corrupt state.
//  i_rst_n is synchronous; the row memories are not cleared.

module heat_jacobi_stencil_sweep_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [hjss_pkg::VAL_W-1:0]   i_cell_value,
    input  logic                                i_frame_start,
    // output words
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [hjss_pkg::VAL_W-1:0]   o_new_value,
    output logic [hjss_pkg::IDX_W-1:0]          o_out_row,
    output logic [hjss_pkg::IDX_W-1:0]          o_out_col,
    output logic                                o_run_last,
    output logic                                o_frame_last,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hjss_pkg::PADDR_W-1:0]        paddr,
    input  logic [hjss_pkg::PDATA_W-1:0]        pwdata,
    output logic [hjss_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int VAL_W  = hjss_pkg::VAL_W;
    localparam int ROW_W  = hjss_pkg::ROW_W;
    localparam int COL_W  = hjss_pkg::COL_W;
    localparam int LAP_W  = hjss_pkg::LAP_W;
    localparam int PROD_W = hjss_pkg::PROD_W;
    localparam int SUM_W  = hjss_pkg::SUM_W;
    localparam int IDX_W  = hjss_pkg::IDX_W;
    localparam int FAW    = hjss_pkg::FIFO_AW;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [hjss_pkg::COEF_W-1:0] r_coef;
    logic signed [VAL_W-1:0]     r_src_val;
    logic [IDX_W-1:0]            r_src_row;
    logic [IDX_W-1:0]            r_src_col;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef    <= hjss_pkg::COEF_RST;
            r_src_val <= hjss_pkg::SRC_VAL_RST;
            r_src_row <= hjss_pkg::SRC_ROW_RST;
            r_src_col <= hjss_pkg::SRC_COL_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                hjss_pkg::REG_COEF:    r_coef    <= pwdata[hjss_pkg::COEF_W-1:0];
                hjss_pkg::REG_SRC_VAL: r_src_val <= pwdata[VAL_W-1:0];
                hjss_pkg::REG_SRC_ROW: r_src_row <= pwdata[IDX_W-1:0];
                hjss_pkg::REG_SRC_COL: r_src_col <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            hjss_pkg::REG_COEF:    prdata = hjss_pkg::PDATA_W'(r_coef);
            hjss_pkg::REG_SRC_VAL: prdata = r_src_val;
            hjss_pkg::REG_SRC_ROW: prdata = hjss_pkg::PDATA_W'(r_src_row);
            hjss_pkg::REG_SRC_COL: prdata = hjss_pkg::PDATA_W'(r_src_col);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Pipe valids, queue occupancy and input flow control
    // ------------------------------------------------------------------------
    logic               r_s1_v, r_s2_v, r_s3_v;
    logic [FAW:0]       r_cnt;
    logic [FAW:0]       used;
    logic               accept;

    assign used       = r_cnt + (FAW+1)'(r_s1_v) + (FAW+1)'(r_s2_v) + (FAW+1)'(r_s3_v);
    assign o_in_ready = (used < (FAW+1)'(hjss_pkg::FIFO_DEPTH));
    assign accept     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------------
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] row_in;
    logic [COL_W-1:0] col_in;
    logic [COL_W-1:0] col_nxt;
    logic [ROW_W-1:0] row_nxt;
    logic             col_wrap;

    always_comb begin
        row_in   = i_frame_start ? '0 : r_row;
        col_in   = i_frame_start ? '0 : r_col;
        col_wrap = (col_in == COL_W'(hjss_pkg::GRID_COLS - 1));
        col_nxt  = col_wrap ? '0 : col_in + 1'b1;
        if (!col_wrap) begin
            row_nxt = row_in;
        end else if (row_in == ROW_W'(hjss_pkg::GRID_ROWS - 1)) begin
            row_nxt = '0;
        end else begin
            row_nxt = row_in + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= row_nxt;
            r_col <= col_nxt;
        end
    end

    // ------------------------------------------------------------------------
    // Row memories: previous row read at c and c+1, written with the new
    // word (read-before-write); older row read at c, written in the following
    // cycle with the center value.
    // ------------------------------------------------------------------------
    logic [VAL_W-1:0] prev_mem  [hjss_pkg::GRID_COLS];
    logic [VAL_W-1:0] older_mem [hjss_pkg::GRID_COLS];
    logic [VAL_W-1:0] r_rd_c, r_rd_e, r_rd_n;
    logic [COL_W-1:0] r_s1_col;
    logic signed [VAL_W-1:0] center;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_c           <= prev_mem[col_in];
            r_rd_e           <= prev_mem[col_nxt];
            prev_mem[col_in] <= i_cell_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_n <= older_mem[col_in];
        end
        if (r_s1_v) begin
            older_mem[r_s1_col] <= center;
        end
    end

    // older-row forward when the next word hits the entry written this cycle
    logic                    r_fwd_n;
    logic signed [VAL_W-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_n <= 1'b0;
        end else if (accept) begin
            r_fwd_n <= r_s1_v && (col_in == r_s1_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd_data <= center;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: gather the window and form the Laplacian
    // ------------------------------------------------------------------------
    logic signed [VAL_W-1:0] r_s1_x;
    logic [ROW_W-1:0]        r_s1_row;
    logic signed [VAL_W-1:0] r_win_c;
    logic signed [VAL_W-1:0] north, east;
    logic signed [LAP_W-1:0] lap;
    logic                    s1_interior;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x   <= i_cell_value;
            r_s1_row <= row_in;
            r_s1_col <= col_in;
        end
    end

    // west neighbor: center value of the previous word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_c <= '0;
        end else if (r_s1_v) begin
            r_win_c <= center;
        end
    end

    always_comb begin
        center = r_rd_c;
        east   = r_rd_e;
        north  = r_fwd_n ? r_fwd_data : r_rd_n;
        lap    = LAP_W'(north) + LAP_W'(r_s1_x) + LAP_W'(r_win_c) + LAP_W'(east)
               - (LAP_W'(center) <<< 2);
        s1_interior = (r_s1_row >= ROW_W'(2)) && (r_s1_col != '0)
                   && (r_s1_col <= COL_W'(hjss_pkg::GRID_COLS - 2));
    end

    // ------------------------------------------------------------------------
    // Stage 2: scale by k
    // ------------------------------------------------------------------------
    logic signed [LAP_W-1:0] r_s2_lap;
    logic signed [VAL_W-1:0] r_s2_center, r_s2_x;
    logic [ROW_W-1:0]        r_s2_row;
    logic [COL_W-1:0]        r_s2_col;
    logic                    r_s2_int;
    logic signed [PROD_W-1:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_lap    <= lap;
        r_s2_center <= center;
        r_s2_x      <= r_s1_x;
        r_s2_row    <= r_s1_row;
        r_s2_col    <= r_s1_col;
        r_s2_int    <= s1_interior;
    end

    assign prod = $signed({1'b0, r_coef}) * r_s2_lap;

    // ------------------------------------------------------------------------
    // Stage 3: round, add, saturate, apply the source and queue the results
    // ------------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_s3_prod;
    logic signed [VAL_W-1:0]  r_s3_center, r_s3_x;
    logic [ROW_W-1:0]         r_s3_row;
    logic [COL_W-1:0]         r_s3_col;
    logic                     r_s3_int;
    logic signed [PROD_W-1:0] rnd;
    logic signed [SUM_W-1:0]  upd;
    logic signed [VAL_W-1:0]  sat_val;
    logic [ROW_W-1:0]         er;
    logic                     last_row;
    logic                     src_hit0, src_hit1;
    logic                     push;
    hjss_pkg::t_pair          pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_prod   <= prod;
        r_s3_center <= r_s2_center;
        r_s3_x      <= r_s2_x;
        r_s3_row    <= r_s2_row;
        r_s3_col    <= r_s2_col;
        r_s3_int    <= r_s2_int;
    end

    always_comb begin
        // round half up, then shift out the fraction (delta keeps its sign)
        rnd = r_s3_prod + PROD_W'(1 << (hjss_pkg::FRAC_W - 1));
        upd = SUM_W'(r_s3_center) + SUM_W'($signed(rnd[PROD_W-1:hjss_pkg::FRAC_W]));
        if (upd > SUM_W'(hjss_pkg::VAL_MAX)) begin
            sat_val = hjss_pkg::VAL_MAX;
        end else if (upd < SUM_W'(hjss_pkg::VAL_MIN)) begin
            sat_val = hjss_pkg::VAL_MIN;
        end else begin
            sat_val = upd[VAL_W-1:0];
        end

        er       = r_s3_row - 1'b1;
        last_row = (r_s3_row == ROW_W'(hjss_pkg::GRID_ROWS - 1));
        src_hit0 = (hjss_pkg::RCMP_W'(er) == hjss_pkg::RCMP_W'(r_src_row))
                && (hjss_pkg::CCMP_W'(r_s3_col) == hjss_pkg::CCMP_W'(r_src_col));
        src_hit1 = (hjss_pkg::RCMP_W'(r_s3_row) == hjss_pkg::RCMP_W'(r_src_row))
                && (hjss_pkg::CCMP_W'(r_s3_col) == hjss_pkg::CCMP_W'(r_src_col));

        pair.val0   = src_hit0 ? r_src_val : (r_s3_int ? sat_val : r_s3_center);
        pair.val1   = src_hit1 ? r_src_val : r_s3_x;
        pair.row0   = IDX_W'(er);
        pair.row1   = IDX_W'(r_s3_row);
        pair.col    = IDX_W'(r_s3_col);
        pair.dual   = last_row;
        pair.flast1 = (r_s3_col == COL_W'(hjss_pkg::GRID_COLS - 1));

        // row 0 words only fill the row memories
        push = r_s3_v && (r_s3_row != '0);
    end

    // ------------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------------
    hjss_pkg::t_pair r_fifo [hjss_pkg::FIFO_DEPTH];
    hjss_pkg::t_pair head;
    logic [FAW-1:0]  r_wp, r_rp;
    logic            r_sub;
    logic            pop;

    assign head        = r_fifo[r_rp];
    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && i_out_ready && (!head.dual || r_sub);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_sub <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp  <= r_rp + 1'b1;
                r_sub <= 1'b0;
            end else if (o_out_valid && i_out_ready) begin
                r_sub <= 1'b1;
            end
            r_cnt <= r_cnt + (FAW+1)'(push) - (FAW+1)'(pop);
        end
    end

    // output word select: second result of a last-row word after the first
    assign o_new_value  = r_sub ? head.val1 : head.val0;
    assign o_out_row    = r_sub ? head.row1 : head.row0;
    assign o_out_col    = head.col;
    assign o_run_last   = !head.dual || r_sub;
    assign o_frame_last = r_sub && head.flast1;

endmodule

// File: hdl/hjss_checker.sv
// ============================================================================
// hjss_checker
// Port-level checks for the stencil sweep unit, bound to the top level.
// ============================================================================

module hjss_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic signed [hjss_pkg::VAL_W-1:0] o_new_value,
    input logic [hjss_pkg::IDX_W-1:0]        o_out_col,
    input logic                              o_run_last,
    input logic                              o_frame_last
);

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a first result of a pair is always followed by its partner at once
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_run_last
        |=> o_out_valid && o_run_last && (o_out_col == $past(o_out_col)))
        else $error("second result of a last-row word missing");

    // the final grid cell closes its input word
    a_frame_last_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_last |-> o_run_last)
        else $error("frame end inside a run");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_new_value))
        else $error("output word changed while stalled");

endmodule

bind heat_jacobi_stencil_sweep_unit hjss_checker u_hjss_checker (.*);
